// ===== src/first_fit_slot_reserver_macros.svh =====
// ---------------------------------------------------------------------------
// first_fit_slot_reserver assertion macros
// Short forms for the concurrent checks of the slot reserver.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_SLOT_RESERVER_MACROS_SVH
`define FIRST_FIT_SLOT_RESERVER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define FFSR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define FFSR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ffsr_pkg.sv =====
// ---------------------------------------------------------------------------
// ffsr_pkg
// Shared widths, codes and types of the first-fit slot reserver.
// ---------------------------------------------------------------------------
`default_nettype none

package ffsr_pkg;

  // Default geometry
  localparam int RESOURCES_DEF  = 8;
  localparam int DAYS_DEF       = 5;
  localparam int SLOTS_DEF      = 14;
  localparam int FIRST_HOUR_DEF = 7;

  // Fixed field widths
  localparam int DAY_W     = 3;
  localparam int HOUR_W    = 5;
  localparam int DEMAND_W  = 8;
  localparam int RES_W     = 3;
  localparam int COUNT_W   = 4;
  localparam int CAP_W     = 8;
  localparam int CAP_TAB_W = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 64;
  // Hour compare width: covers 31 and FIRST_HOUR + SLOTS up to 47
  localparam int HCMP_W    = 6;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESOURCE_COUNT = 2'd0,
    CFG_CAPACITY_TABLE = 2'd1
  } cfg_idx_e;

  // Result codes
  typedef enum logic [1:0] {
    ST_GRANTED   = 2'd0,
    ST_NONE_FREE = 2'd1,
    ST_INVALID   = 2'd2
  } status_e;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_e;

  // One result item from the controller
  typedef struct packed {
    logic             valid;
    status_e          status;
    logic [RES_W-1:0] resource;
  } result_t;

endpackage : ffsr_pkg

`default_nettype wire

// ===== src/ffsr_mem.sv =====
// ---------------------------------------------------------------------------
// ffsr_mem
// Occupancy store: one word per resource and day, registered read, one
// write port. Per-entry valid flags make every word read as free after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module ffsr_mem
  import ffsr_pkg::*;
#(
  parameter int DEPTH = RESOURCES_DEF * DAYS_DEF,
  parameter int AW    = 6,
  parameter int SW    = SLOTS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [SW-1:0] rd_data_o,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [SW-1:0] wr_data_i
);

  logic [SW-1:0]    mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [SW-1:0]    rd_data_q;

  // Mark written entries; reset frees every word at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read; an unwritten entry reads as all free
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= vld_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule : ffsr_mem

`default_nettype wire

// ===== src/ffsr_ctrl.sv =====
// ---------------------------------------------------------------------------
// ffsr_ctrl
// Request check and first-fit scan: reads one resource word per cycle,
// tests capacity and overlap, writes back the marked word on a grant.
// ---------------------------------------------------------------------------
`default_nettype none

module ffsr_ctrl
  import ffsr_pkg::*;
#(
  parameter int DAYS       = DAYS_DEF,
  parameter int SLOTS      = SLOTS_DEF,
  parameter int FIRST_HOUR = FIRST_HOUR_DEF,
  parameter int AW         = 6
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [DAY_W-1:0]     day_i,
  input  wire logic [HOUR_W-1:0]    start_hour_i,
  input  wire logic [HOUR_W-1:0]    end_hour_i,
  input  wire logic [DEMAND_W-1:0]  demand_i,
  input  wire logic [COUNT_W-1:0]   count_i,
  input  wire logic [CAP_TAB_W-1:0] cap_table_i,
  output logic                      rd_en_o,
  output logic      [AW-1:0]        rd_addr_o,
  input  wire logic [SLOTS-1:0]     rd_data_i,
  output logic                      wr_en_o,
  output logic      [AW-1:0]        wr_addr_o,
  output logic      [SLOTS-1:0]     wr_data_o,
  output result_t                   result_o
);

  localparam logic [HCMP_W-1:0] FH    = HCMP_W'(FIRST_HOUR);
  localparam logic [HCMP_W-1:0] S_MAX = HCMP_W'(FIRST_HOUR + SLOTS - 1);
  localparam logic [HCMP_W-1:0] E_MAX = HCMP_W'(FIRST_HOUR + SLOTS);

  state_e                state_q, state_d;
  logic [COUNT_W-1:0]    res_q, res_d;
  logic [AW-1:0]         addr_q, addr_d;
  logic [SLOTS-1:0]      need_q, need_d;
  logic [DEMAND_W-1:0]   demand_q, demand_d;
  result_t               result_q, result_d;

  logic [HCMP_W-1:0]     start_ext;
  logic [HCMP_W-1:0]     end_ext;
  logic                  req_ok;
  logic [CAP_W-1:0]      cap;
  logic                  fits;
  logic [COUNT_W-1:0]    res_nxt;
  logic [AW-1:0]         addr_nxt;

  // Range check of day and hours
  assign start_ext = HCMP_W'(start_hour_i);
  assign end_ext   = HCMP_W'(end_hour_i);
  assign req_ok    = ({1'b0, day_i} < (DAY_W + 1)'(DAYS)) &&
                     (start_ext >= FH) && (start_ext <= S_MAX) &&
                     (end_ext >= FH) && (end_ext <= E_MAX);

  // Slots wanted: slot k booked when start <= FIRST_HOUR + k < end
  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      need_d[k] = (start_ext <= FH + HCMP_W'(k)) && (end_ext > FH + HCMP_W'(k));
    end
  end

  // Test the resource whose word is on the read port
  assign cap      = CAP_W'(cap_table_i >> {res_q[RES_W-1:0], 3'b000});
  assign fits     = (cap >= demand_q) && ((rd_data_i & need_q) == '0);
  assign res_nxt  = res_q + COUNT_W'(1);
  assign addr_nxt = addr_q + AW'(DAYS);

  // Next state, memory requests and result
  always_comb begin
    state_d         = state_q;
    res_d           = res_q;
    addr_d          = addr_q;
    demand_d        = demand_q;
    rd_en_o         = 1'b0;
    rd_addr_o       = addr_q;
    wr_en_o         = 1'b0;
    wr_addr_o       = addr_q;
    wr_data_o       = rd_data_i | need_q;
    result_d        = '0;
    result_d.status = ST_NONE_FREE;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          demand_d = demand_i;
          if (!req_ok) begin
            result_d.valid  = 1'b1;
            result_d.status = ST_INVALID;
          end else if (count_i == '0) begin
            result_d.valid = 1'b1;
          end else begin
            // issue the read for resource zero of this day
            res_d     = '0;
            addr_d    = AW'(day_i);
            rd_en_o   = 1'b1;
            rd_addr_o = AW'(day_i);
            state_d   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (fits) begin
          // grant and write back the marked word
          wr_en_o           = 1'b1;
          result_d.valid    = 1'b1;
          result_d.status   = ST_GRANTED;
          result_d.resource = res_q[RES_W-1:0];
          state_d           = S_IDLE;
        end else if (res_nxt >= count_i) begin
          result_d.valid = 1'b1;
          state_d        = S_IDLE;
        end else begin
          // advance to the next resource
          res_d     = res_nxt;
          addr_d    = addr_nxt;
          rd_en_o   = 1'b1;
          rd_addr_o = addr_nxt;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      result_q <= '0;
    end else begin
      state_q  <= state_d;
      result_q <= result_d;
    end
  end

  // Item registers; need and demand held while scanning, resource and address advance
  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    addr_q   <= addr_d;
    demand_q <= demand_d;
    if (state_q == S_IDLE) begin
      need_q <= need_d;
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign result_o = result_q;

endmodule : ffsr_ctrl

`default_nettype wire

// ===== src/first_fit_slot_reserver.sv =====
// ---------------------------------------------------------------------------
// first_fit_slot_reserver
// First-fit reservation of hourly slots over a set of resources and days.
// ---------------------------------------------------------------------------
//
//   channel   handshake                      payload
//   request   start / busy                   day_of_week, start/end hour, demand
//   result    result_valid_o (strobe)        status, granted_resource
//   config    cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// A bad request or a resource count of zero answers in the cycle after it is taken.
// A valid request answers once the scan ends, after at most RESOURCES resources are
// examined; the scan makes one memory read per cycle.
// Reset frees every slot at once through per-word valid flags; no clearing pass.
// busy is high while a scan runs; results are shown for one cycle only.
// Configuration writes wait while a request is offered or a scan runs.
// ---------------------------------------------------------------------------
`default_nettype none

`include "first_fit_slot_reserver_macros.svh"

module first_fit_slot_reserver
  import ffsr_pkg::*;
#(
  parameter int RESOURCES  = RESOURCES_DEF,
  parameter int DAYS       = DAYS_DEF,
  parameter int SLOTS      = SLOTS_DEF,
  parameter int FIRST_HOUR = FIRST_HOUR_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [DAY_W-1:0]     day_of_week_i,
  input  wire logic [HOUR_W-1:0]    start_hour_i,
  input  wire logic [HOUR_W-1:0]    end_hour_i,
  input  wire logic [DEMAND_W-1:0]  demand_i,
  output logic                      result_valid_o,
  output logic      [1:0]           status_o,
  output logic      [RES_W-1:0]     granted_resource_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i
);

  localparam int DEPTH = RESOURCES * DAYS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [COUNT_W-1:0]   res_count_q;
  logic [CAP_TAB_W-1:0] cap_table_q;
  logic [COUNT_W-1:0]   count_eff;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [SLOTS-1:0]     rd_data;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [SLOTS-1:0]     wr_data;
  result_t              result;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_count_q <= '0;
      cap_table_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_RESOURCE_COUNT: res_count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_CAPACITY_TABLE: cap_table_q <= cfg_data_i[CAP_TAB_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold writes off while a request is offered or in flight
  assign cfg_ready_o = !busy && !start;

  // Clamp the scanned count to the resources built
  assign count_eff = (res_count_q > COUNT_W'(RESOURCES)) ? COUNT_W'(RESOURCES)
                                                         : res_count_q;

  ffsr_ctrl #(
    .DAYS       (DAYS),
    .SLOTS      (SLOTS),
    .FIRST_HOUR (FIRST_HOUR),
    .AW         (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .day_i        (day_of_week_i),
    .start_hour_i (start_hour_i),
    .end_hour_i   (end_hour_i),
    .demand_i     (demand_i),
    .count_i      (count_eff),
    .cap_table_i  (cap_table_q),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .result_o     (result)
  );

  ffsr_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .SW    (SLOTS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign result_valid_o     = result.valid;
  assign status_o           = result.status;
  assign granted_resource_o = result.resource;

  // Checks
  `FFSR_ASSERT_NXT(a_taken_progress, clk_i, rst_ni, start && !busy,
                   result_valid_o || busy, "accepted item neither answered nor busy")
  `FFSR_ASSERT_IMP(a_grant_in_range, clk_i, rst_ni,
                   result_valid_o && status_o == ST_GRANTED,
                   {1'b0, granted_resource_o} < count_eff, "grant beyond resource count")
  `FFSR_ASSERT_IMP(a_nogrant_zero, clk_i, rst_ni,
                   result_valid_o && status_o != ST_GRANTED,
                   granted_resource_o == '0, "resource index set without grant")
  `FFSR_ASSERT_IMP(a_wr_ends_scan, clk_i, rst_ni, wr_en,
                   busy && !rd_en, "write back outside the final scan cycle")

endmodule : first_fit_slot_reserver

`default_nettype wire

// ===== sim/first_fit_slot_reserver_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// first_fit_slot_reserver_test
// Self-checking bench for the first-fit slot reserver. A scripted opening
// covers empty and full registers, every rejection and the empty interval.
// Random phases then book slots under a range of capacity settings. Every
// result is compared, in order, with the script's outcome or an in-bench occupancy model.
// ---------------------------------------------------------------------------
module first_fit_slot_reserver_test;
  import ffsr_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = RESOURCES_DEF + 2;
  localparam int NUM_ROWS      = 29;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 250;
  localparam int QUIET_PHASE   = 3;
  localparam int PAUSE_PHASE   = 1;
  localparam int PAUSE_ITEM    = 125;
  localparam int LAST_HOUR_END = FIRST_HOUR_DEF + SLOTS_DEF;

  // Register indexes that map to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 2'd3;

  typedef struct {
    status_e          status;
    logic [RES_W-1:0] resource;
  } booking_t;

  typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DAT_W-1:0]  data;
    logic [DAY_W-1:0]      day;
    logic [HOUR_W-1:0]     first_hour;
    logic [HOUR_W-1:0]     stop_hour;
    logic [DEMAND_W-1:0]   demand;
    logic                  typed;
    booking_t              outcome;
  } script_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [DAY_W-1:0]     day_of_week_i = '0;
  logic [HOUR_W-1:0]    start_hour_i = '0;
  logic [HOUR_W-1:0]    end_hour_i = '0;
  logic [DEMAND_W-1:0]  demand_i = '0;
  logic                 result_valid_o;
  logic [1:0]           status_o;
  logic [RES_W-1:0]     granted_resource_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  // Bench copy of the registers and the occupancy store
  logic [COUNT_W-1:0]   res_count = '0;
  logic [CAP_TAB_W-1:0] cap_table = '0;
  logic [SLOTS_DEF-1:0] occupancy [RESOURCES_DEF*DAYS_DEF] = '{default: '0};

  booking_t    bookings_due[$];
  script_row_t script [NUM_ROWS];
  int          errors = 0;
  int          cycles = 0;
  bit          sender_idles = 1'b1;

  first_fit_slot_reserver dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .day_of_week_i      (day_of_week_i),
    .start_hour_i       (start_hour_i),
    .end_hour_i         (end_hour_i),
    .demand_i           (demand_i),
    .result_valid_o     (result_valid_o),
    .status_o           (status_o),
    .granted_resource_o (granted_resource_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Grant the first resource that fits and mark its slots
  function automatic booking_t reserve_slots(input logic [DAY_W-1:0] day,
                                             input logic [HOUR_W-1:0] first_hour,
                                             input logic [HOUR_W-1:0] stop_hour,
                                             input logic [DEMAND_W-1:0] demand);
    booking_t             b;
    int                   scan;
    logic [SLOTS_DEF-1:0] want;
    logic [CAP_W-1:0]     cap;
    b.status   = ST_NONE_FREE;
    b.resource = '0;
    scan = (res_count > RESOURCES_DEF) ? RESOURCES_DEF : int'(res_count);
    if (day >= DAYS_DEF || first_hour < FIRST_HOUR_DEF ||
        first_hour > LAST_HOUR_END - 1 || stop_hour < FIRST_HOUR_DEF ||
        stop_hour > LAST_HOUR_END) begin
      b.status = ST_INVALID;
      return b;
    end
    want = '0;
    for (int h = first_hour; h < stop_hour; h++) want[h - FIRST_HOUR_DEF] = 1'b1;
    for (int r = 0; r < scan; r++) begin
      cap = cap_table[CAP_W*r +: CAP_W];
      if (cap >= demand && (occupancy[r*DAYS_DEF + day] & want) == '0) begin
        occupancy[r*DAYS_DEF + day] |= want;
        b.status   = ST_GRANTED;
        b.resource = RES_W'(r);
        return b;
      end
    end
    return b;
  endfunction

  function automatic script_row_t row_request(input logic [DAY_W-1:0] day,
                                              input logic [HOUR_W-1:0] first_hour,
                                              input logic [HOUR_W-1:0] stop_hour,
                                              input logic [DEMAND_W-1:0] demand);
    script_row_t row;
    row.kind             = ROW_REQUEST;
    row.idx              = '0;
    row.data             = '0;
    row.day              = day;
    row.first_hour       = first_hour;
    row.stop_hour        = stop_hour;
    row.demand           = demand;
    row.typed            = 1'b0;
    row.outcome.status   = ST_GRANTED;
    row.outcome.resource = '0;
    return row;
  endfunction

  // Request whose outcome is written out in the script
  function automatic script_row_t row_checked(input logic [DAY_W-1:0] day,
                                              input logic [HOUR_W-1:0] first_hour,
                                              input logic [HOUR_W-1:0] stop_hour,
                                              input logic [DEMAND_W-1:0] demand,
                                              input status_e status);
    script_row_t row;
    row = row_request(day, first_hour, stop_hour, demand);
    row.typed          = 1'b1;
    row.outcome.status = status;
    return row;
  endfunction

  function automatic script_row_t row_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DAT_W-1:0] data);
    script_row_t row;
    row = row_request('0, '0, '0, '0);
    row.kind = ROW_WRITE;
    row.idx  = idx;
    row.data = data;
    return row;
  endfunction

  // Mostly well-formed bookings, some empty intervals, a little noise
  function automatic script_row_t random_request();
    int                  kind;
    int                  first_hour;
    int                  stop_hour;
    logic [DAY_W-1:0]    day;
    logic [DEMAND_W-1:0] demand;
    kind   = $urandom_range(99);
    demand = $urandom_range(1) ? DEMAND_W'($urandom_range(255))
                               : DEMAND_W'($urandom_range(40));
    if (kind < 8) begin
      day        = DAY_W'($urandom);
      first_hour = $urandom_range(31);
      stop_hour  = $urandom_range(31);
    end else begin
      day        = DAY_W'($urandom_range(DAYS_DEF - 1));
      first_hour = $urandom_range(FIRST_HOUR_DEF, LAST_HOUR_END - 1);
      if (kind < 16)
        stop_hour = $urandom_range(FIRST_HOUR_DEF, first_hour);
      else
        stop_hour = first_hour + $urandom_range(1, (kind < 26) ? 6 : 2);
      if (stop_hour > LAST_HOUR_END) stop_hour = LAST_HOUR_END;
    end
    return row_request(day, HOUR_W'(first_hour), HOUR_W'(stop_hour), demand);
  endfunction

  // Drop start and hold until every booking result is back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (bookings_due.size() != 0);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_RESOURCE_COUNT: res_count = data[COUNT_W-1:0];
      CFG_CAPACITY_TABLE: cap_table = data;
      default: ;
    endcase
  endtask

  // Offer one item, wait for it to be taken, then queue its outcome
  task automatic send_request(input script_row_t row);
    booking_t predicted;
    while (sender_idles && $urandom_range(99) < 23) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start         <= 1'b1;
    day_of_week_i <= row.day;
    start_hour_i  <= row.first_hour;
    end_hour_i    <= row.stop_hour;
    demand_i      <= row.demand;
    do @(posedge clk_i); while (busy);
    predicted = reserve_slots(row.day, row.first_hour, row.stop_hour, row.demand);
    bookings_due.push_back(row.typed ? row.outcome : predicted);
  endtask

  // Compare each result strobe with the oldest outstanding booking
  always @(posedge clk_i) begin
    booking_t want;
    if (rst_ni && result_valid_o) begin
      if (bookings_due.size() == 0) begin
        $display("%0t: unexpected result, status %0d resource %0d",
                 $time, status_o, granted_resource_o);
        errors++;
      end else begin
        want = bookings_due.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, status_o);
          errors++;
        end
        if (granted_resource_o !== want.resource) begin
          $display("%0t: granted_resource expected %0d, got %0d",
                   $time, want.resource, granted_resource_o);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [CFG_DAT_W-1:0] phase_count [PHASES];
    logic [CFG_DAT_W-1:0] phase_caps [PHASES];

    // r0 10, r1 50, r2 255, r3 0, r4 128, r5 64, r6 32, r7 16
    script = '{
      row_checked(0, 7, 8, 0, ST_NONE_FREE),       // nothing configured yet
      row_checked(5, 7, 8, 0, ST_INVALID),         // day past the week
      row_checked(7, 31, 31, 255, ST_INVALID),     // every field at its top
      row_checked(0, 0, 0, 0, ST_INVALID),         // every field at zero
      row_write(CFG_RESOURCE_COUNT, 64'd3),
      row_write(CFG_CAPACITY_TABLE, 64'h1020_4080_00FF_320A),
      row_request(0, 7, 21, 0),                    // whole day, r0
      row_request(0, 7, 21, 0),                    // r1
      row_request(0, 7, 21, 0),                    // r2
      row_checked(0, 7, 21, 0, ST_NONE_FREE),      // all three full
      row_request(0, 12, 12, 0),                   // empty interval on a full day
      row_request(0, 15, 9, 0),                    // end before start
      row_checked(1, 6, 8, 0, ST_INVALID),         // start below the first hour
      row_checked(1, 21, 21, 0, ST_INVALID),       // start past the last slot
      row_checked(1, 7, 22, 0, ST_INVALID),        // end past the closing hour
      row_checked(1, 7, 6, 0, ST_INVALID),         // end below the first hour
      row_request(1, 20, 21, 11),                  // too big for r0
      row_request(1, 20, 21, 255),
      row_request(1, 20, 21, 51),
      row_write(CFG_RESOURCE_COUNT, 64'd15),       // clamps to all resources
      row_write(CFG_UNMAPPED_LO, '1),
      row_write(CFG_UNMAPPED_HI, '0),
      row_request(2, 7, 9, 128),
      row_request(2, 7, 9, 128),
      row_request(2, 8, 9, 16),
      row_request(4, 7, 21, 255),
      row_request(4, 7, 8, 255),
      row_write(CFG_RESOURCE_COUNT, 64'd0),
      row_checked(3, 7, 21, 0, ST_NONE_FREE)       // no resources in use
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Scripted opening
    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE)
        write_register(script[i].idx, script[i].data);
      else
        send_request(script[i]);
    end

    // Random phases: full, random, minimal, clamped, empty, random
    phase_count = '{64'd8, {$urandom, $urandom}, 64'd1, '1, 64'd0, {$urandom, $urandom}};
    phase_caps  = '{'1, {$urandom, $urandom}, '0, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}};
    for (int phase = 0; phase < PHASES; phase++) begin
      write_register(CFG_RESOURCE_COUNT, phase_count[phase]);
      write_register(CFG_CAPACITY_TABLE, phase_caps[phase]);
      sender_idles = (phase != QUIET_PHASE);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == PAUSE_PHASE && n == PAUSE_ITEM) drain_results();
        send_request(random_request());
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== first_fit_slot_reserver.f =====
+incdir+src
src/ffsr_pkg.sv
src/ffsr_mem.sv
src/ffsr_ctrl.sv
src/first_fit_slot_reserver.sv
sim/first_fit_slot_reserver_test.sv
